// File: design/hdr_pkg.sv
// ----------------------------------------------------------------------------
// hdr_pkg
// Shared types and constants for the H-bridge dead-time reversal unit.
// ----------------------------------------------------------------------------
package hdr_pkg;

    localparam int unsigned CMD_W      = 16;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned SCALE_W    = 9;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned DEADTIME_W = 16;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [DEADTIME_W-1:0] DEADTIME_RESET = 16'd1200;
    localparam logic [SCALE_W-1:0]    SCALE_FULL     = 9'd256;

    typedef enum logic [1:0] {
        PH_RUN  = 2'd0,
        PH_DEAD = 2'd1,
        PH_SET  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DIR_ZERO = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t              bridge;
        logic [DUTY_W-1:0] duty;
    } lane_out_t;

endpackage

// File: design/hdr_lane.sv
// ----------------------------------------------------------------------------
// hdr_lane
// One bridge side: command clamp, direction tracking, dead-time wait, duty.
// ----------------------------------------------------------------------------
module hdr_lane #(
    parameter int unsigned PWM_TOP = 1023
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [hdr_pkg::NOW_W-1:0]            now_us,
    input  logic signed [hdr_pkg::CMD_W-1:0]     cmd,
    input  logic [hdr_pkg::SCALE_W-1:0]          scale,
    input  logic [hdr_pkg::DEADTIME_W-1:0]       dead_time,
    output hdr_pkg::lane_out_t                   result
);

    localparam int unsigned MAG_W  = hdr_pkg::CMD_W - 1;
    localparam int unsigned PROD_W = MAG_W + hdr_pkg::SCALE_W;
    localparam logic signed [hdr_pkg::CMD_W:0] TOP_S = (hdr_pkg::CMD_W+1)'(PWM_TOP);

    hdr_pkg::phase_t           phase_reg, phase_next;
    hdr_pkg::dir_t             applied_reg, applied_next;
    hdr_pkg::dir_t             drive_reg, drive_next;
    logic [hdr_pkg::NOW_W-1:0] start_reg, start_next;

    logic signed [hdr_pkg::CMD_W:0] cmd_ext;
    logic [MAG_W-1:0]               mag;
    hdr_pkg::dir_t                  dir;
    logic [PROD_W-1:0]              prod;
    logic [hdr_pkg::NOW_W-1:0]      elapsed;

    always_comb
    begin
        cmd_ext = {cmd[hdr_pkg::CMD_W-1], cmd};
        if (cmd_ext > TOP_S || cmd_ext < -TOP_S)
        begin
            mag = MAG_W'(PWM_TOP);
        end
        else if (cmd_ext < 0)
        begin
            mag = MAG_W'(-cmd_ext);
        end
        else
        begin
            mag = MAG_W'(cmd_ext);
        end
        if (cmd_ext > 0)
        begin
            dir = hdr_pkg::DIR_FWD;
        end
        else if (cmd_ext < 0)
        begin
            dir = hdr_pkg::DIR_REV;
        end
        else
        begin
            dir = hdr_pkg::DIR_ZERO;
        end
        prod    = PROD_W'(mag) * PROD_W'(scale);
        elapsed = now_us - start_reg;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        applied_next = applied_reg;
        drive_next   = drive_reg;
        start_next   = start_reg;
        result.duty  = '0;
        case (phase_reg)
            hdr_pkg::PH_DEAD:
            begin
                if (elapsed >= hdr_pkg::NOW_W'(dead_time))
                begin
                    phase_next = hdr_pkg::PH_SET;
                end
            end
            hdr_pkg::PH_SET:
            begin
                drive_next   = dir;
                applied_next = dir;
                phase_next   = hdr_pkg::PH_RUN;
            end
            default:
            begin
                if (dir != applied_reg)
                begin
                    drive_next = hdr_pkg::DIR_ZERO;
                    start_next = now_us;
                    phase_next = hdr_pkg::PH_DEAD;
                end
                else
                begin
                    result.duty = prod[PROD_W-1:8];
                end
            end
        endcase
        result.bridge = drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hdr_pkg::PH_RUN;
            applied_reg <= hdr_pkg::DIR_ZERO;
            drive_reg   <= hdr_pkg::DIR_ZERO;
            start_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            applied_reg <= applied_next;
            drive_reg   <= drive_next;
            start_reg   <= start_next;
        end
    end

endmodule

// File: design/hdr_out_buf.sv
// ----------------------------------------------------------------------------
// hdr_out_buf
// Merges both lane results into one output word and holds it in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module hdr_out_buf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  hdr_pkg::lane_out_t                left,
    input  hdr_pkg::lane_out_t                right,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hdr_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int unsigned PAD_W = hdr_pkg::OUT_DATA_W - 2*hdr_pkg::DUTY_W - 4;

    logic [hdr_pkg::OUT_DATA_W-1:0] merged;
    logic [hdr_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [hdr_pkg::OUT_DATA_W-1:0] skid_data_reg;
    logic                           out_valid_reg;
    logic                           skid_valid_reg;
    logic                           in_fire;
    logic                           out_fire;

    assign merged = {{PAD_W{1'b0}}, right.bridge, left.bridge, right.duty, left.duty};

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= merged;
            end
            else
            begin
                out_data_reg <= merged;
            end
        end
    end

endmodule

// File: design/hbridge_deadtime_reversal_unit.sv
// ----------------------------------------------------------------------------
// hbridge_deadtime_reversal_unit
// Two-side H-bridge drive with dead time on every direction reversal.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one update transaction: tdata holds now_us, cmd_left,
//   cmd_right and power_scale. m_axis returns one transaction per update with
//   duty_left, duty_right, bridge_left and bridge_right.
//   cfg_we/cfg_wdata write the dead time in microseconds; write only while
//   no update is pending at the output.
//   A result is registered when its update is taken: in the output register,
//   or in the skid register while m_axis stalls. Throughput: one update per
//   cycle unless m_axis stalls; both sides are handled by parallel lanes whose
//   state steps in the accepting cycle, and the per-side multiply is the longest path.
//   A skid register behind the output register keeps s_axis_tready high for
//   one extra transaction while m_axis stalls; after that tready drops until
//   the receiver takes data.
//   Reset: both sides go to run with zero direction and bridge off, start
//   time zero, dead time 1200 us, output empty.
// ----------------------------------------------------------------------------
module hbridge_deadtime_reversal_unit #(
    parameter int unsigned PWM_TOP = 1023
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [hdr_pkg::DEADTIME_W-1:0]         cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // now_us[31:0], cmd_left[47:32], cmd_right[63:48], power_scale[72:64], pad
    input  logic [hdr_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // duty_left[15:0], duty_right[31:16], bridge_left[33:32], bridge_right[35:34]
    output logic [hdr_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    logic [hdr_pkg::DEADTIME_W-1:0] deadtime_reg;
    logic                           accept;
    logic [hdr_pkg::NOW_W-1:0]      now_us;
    logic signed [hdr_pkg::CMD_W-1:0] cmd_left;
    logic signed [hdr_pkg::CMD_W-1:0] cmd_right;
    logic [hdr_pkg::SCALE_W-1:0]    scale_raw;
    logic [hdr_pkg::SCALE_W-1:0]    scale;
    hdr_pkg::lane_out_t             res_left;
    hdr_pkg::lane_out_t             res_right;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign now_us    = s_axis_tdata[31:0];
    assign cmd_left  = s_axis_tdata[47:32];
    assign cmd_right = s_axis_tdata[63:48];
    assign scale_raw = s_axis_tdata[72:64];
    assign scale     = (scale_raw > hdr_pkg::SCALE_FULL) ? hdr_pkg::SCALE_FULL : scale_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadtime_reg <= hdr_pkg::DEADTIME_RESET;
        end
        else if (cfg_we)
        begin
            deadtime_reg <= cfg_wdata;
        end
    end

    hdr_lane #(
        .PWM_TOP (PWM_TOP)
    ) u_lane_left (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_us      (now_us),
        .cmd         (cmd_left),
        .scale       (scale),
        .dead_time   (deadtime_reg),
        .result      (res_left)
    );

    hdr_lane #(
        .PWM_TOP (PWM_TOP)
    ) u_lane_right (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_us      (now_us),
        .cmd         (cmd_right),
        .scale       (scale),
        .dead_time   (deadtime_reg),
        .result      (res_right)
    );

    hdr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .left      (res_left),
        .right     (res_right),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
